// ===== rtl/adaptive_peak_valley_step_detector_core_macros.svh =====
// Assertion macros for the adaptive peak/valley step detector.
// Included by the top level; depends on nothing else.
`ifndef ADAPTIVE_PEAK_VALLEY_STEP_DETECTOR_CORE_MACROS_SVH
`define ADAPTIVE_PEAK_VALLEY_STEP_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define APV_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define APV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define APV_ASSERT(lbl, clk, rstn, prop, msg)
`define APV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/apvsd_pkg.sv =====
// Shared types, constants and helpers of the adaptive peak/valley step detector.
// Used by apvsd_adapt and the top level; depends on nothing else.
package apvsd_pkg;

	localparam int WINDOW_LEN = 5;
	localparam int SLOTS      = 5;
	localparam int IDX_W      = 3;   // holds a window position or a slot index
	localparam int SUM_W      = 19;  // five 16-bit values
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_THR_UP     = 16'd1500;
	localparam logic [15:0] RST_THR_DOWN   = 16'd500;
	localparam logic [15:0] RST_THR_WIDE   = 16'd704;
	localparam logic [15:0] RST_REST_LEVEL = 16'd1028;
	localparam logic [7:0]  RST_STRIDE     = 8'd75;
	localparam logic [7:0]  RST_TIMEOUT    = 8'd200;
	localparam logic [7:0]  RST_MIN_VALLEY = 8'd20;

	// Division by five as a multiplication by a rounded-up reciprocal.
	// Exact for every dividend below 2**22.
	localparam int          DIV5_SHIFT = 23;
	localparam logic [20:0] DIV5_MUL   = 21'd1677722;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THR_UP     = 3'd0,
		REG_THR_DOWN   = 3'd1,
		REG_THR_WIDE   = 3'd2,
		REG_REST_LEVEL = 3'd3,
		REG_STRIDE     = 3'd4,
		REG_TIMEOUT    = 3'd5,
		REG_MIN_VALLEY = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] high;
		logic [15:0] low;
		logic [15:0] swing;
	} thr_t;

	function automatic logic [15:0] div5(input logic [SUM_W-1:0] x);
		logic [SUM_W+20:0] p;
		p = (SUM_W + 21)'(x) * (SUM_W + 21)'(DIV5_MUL);
		return p[DIV5_SHIFT +: 16];
	endfunction

endpackage

// ===== rtl/adaptive_peak_valley_step_detector_core.sv =====
// Adaptive peak/valley step detector, top level; depends on apvsd_pkg, apvsd_adapt
// and the assertion macro header. Each accepted beat is one acceleration-magnitude
// sample of a 10 ms tick and yields exactly one result beat: whether this tick
// counted a step, the running step and distance totals, and the walking flag.
// The block takes one sample per clock cycle while it is not stalled. A sample
// is captured in the input register, and once the output register is free or
// being emptied, a single pass of logic (window sum, divide by five, peak/valley
// compare and the threshold adaptation) folds it into the tracking state while
// its result is loaded into the output register, where it waits to be taken.
// A waiting result stalls the input side only
// when the input register is also full. Configuration registers are written
// through a separate valid/ready port that is always ready; write them only while
// no sample is in flight.
`include "adaptive_peak_valley_step_detector_core_macros.svh"

module adaptive_peak_valley_step_detector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [15:0]                        sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               step_now,
	output logic [31:0]                        steps_total,
	output logic [31:0]                        distance_total,
	output logic                               walking,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [apvsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [apvsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import apvsd_pkg::*;

	// Configuration registers.
	logic [15:0] base_up_q, base_down_q, base_wide_q, rest_q;
	logic [7:0]  stride_q, timeout_q, min_valley_q;

	// Input register.
	logic        valid_s1;
	logic [15:0] sample_s1;

	// Output register.
	logic        result_valid_q;
	logic        step_now_q;
	logic        walking_q;

	// Tracking state.
	logic [15:0]      win_q [WINDOW_LEN];
	logic [IDX_W-1:0] win_pos_q;
	logic [15:0]      prev_avg_q;
	logic [15:0]      peak_q [SLOTS];
	logic [15:0]      valley_q [SLOTS];
	logic [7:0]       vtime_q [SLOTS];
	logic [IDX_W-1:0] slot_q;
	thr_t             thr_q;
	logic [7:0]       tick_q;
	logic [31:0]      steps_q;
	logic [31:0]      dist_q;

	// Next-state values.
	logic [15:0]      win_nx [WINDOW_LEN];
	logic [IDX_W-1:0] win_pos_nx;
	logic [15:0]      prev_avg_nx;
	logic [15:0]      peak_nx [SLOTS];
	logic [15:0]      valley_nx [SLOTS];
	logic [7:0]       vtime_nx [SLOTS];
	logic [IDX_W-1:0] slot_nx;
	thr_t             thr_nx;
	logic [7:0]       tick_nx;
	logic [31:0]      steps_nx;
	logic [31:0]      dist_nx;
	logic             walk_nx;
	logic             step;

	// Per-sample intermediates.
	logic              advance;
	logic              timeout;
	logic [7:0]        now;
	logic [IDX_W-1:0]  pos_adv;
	logic [15:0]       win_wr [WINDOW_LEN];
	logic [SUM_W-1:0]  win_sum;
	logic [15:0]       cur;
	logic [15:0]       pk, vl;
	logic [7:0]        vt;
	logic signed [16:0] swing_now;
	logic              falling;
	logic              last_slot;
	logic [IDX_W-1:0]  slot_inc;
	thr_t              thr_adapt;

	// Configuration port.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_up_q    <= RST_THR_UP;
			base_down_q  <= RST_THR_DOWN;
			base_wide_q  <= RST_THR_WIDE;
			rest_q       <= RST_REST_LEVEL;
			stride_q     <= RST_STRIDE;
			timeout_q    <= RST_TIMEOUT;
			min_valley_q <= RST_MIN_VALLEY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THR_UP:     base_up_q    <= cfg_data;
				REG_THR_DOWN:   base_down_q  <= cfg_data;
				REG_THR_WIDE:   base_wide_q  <= cfg_data;
				REG_REST_LEVEL: rest_q       <= cfg_data;
				REG_STRIDE:     stride_q     <= cfg_data[7:0];
				REG_TIMEOUT:    timeout_q    <= cfg_data[7:0];
				REG_MIN_VALLEY: min_valley_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The input register moves on whenever the output register is free or
	// is being emptied in this same cycle.
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	apvsd_adapt u_adapt (
		.peak      (peak_q),
		.valley    (valley_q),
		.base_up   (base_up_q),
		.base_down (base_down_q),
		.base_wide (base_wide_q),
		.thr       (thr_adapt)
	);

	// Moving average: the write position advances before the new sample is
	// stored, and the average is taken over the window including it.
	always_comb begin
		pos_adv = (win_pos_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : win_pos_q + 1'b1;
		win_sum = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			win_wr[i] = (pos_adv == IDX_W'(i)) ? sample_s1 : win_q[i];
			win_sum   = win_sum + SUM_W'(win_wr[i]);
		end
		cur = div5(win_sum);
	end

	assign timeout   = (tick_q >= timeout_q);
	assign now       = tick_q + 8'd1;
	assign pk        = peak_q[slot_q];
	assign vl        = valley_q[slot_q];
	assign vt        = vtime_q[slot_q];
	// A valley may lie above its peak, so the swing is taken signed.
	assign swing_now = $signed({1'b0, pk}) - $signed({1'b0, vl});
	assign falling   = (cur < thr_q.low) || (swing_now > $signed({1'b0, thr_q.swing}));
	assign last_slot = (slot_q == IDX_W'(SLOTS - 1));
	assign slot_inc  = slot_q + 1'b1;

	// Tracking update for the sample in the input register.
	always_comb begin
		win_nx      = win_q;
		win_pos_nx  = win_pos_q;
		prev_avg_nx = prev_avg_q;
		peak_nx     = peak_q;
		valley_nx   = valley_q;
		vtime_nx    = vtime_q;
		slot_nx     = slot_q;
		thr_nx      = thr_q;
		tick_nx     = tick_q;
		steps_nx    = steps_q;
		dist_nx     = dist_q;
		walk_nx     = walking_q;
		step        = 1'b0;

		if (timeout) begin
			// Too long without a step: drop the sample and start over. The
			// totals are kept.
			thr_nx.high  = base_up_q;
			thr_nx.low   = base_down_q;
			thr_nx.swing = base_wide_q;
			for (int i = 0; i < SLOTS; i++) begin
				peak_nx[i]   = rest_q;
				valley_nx[i] = rest_q;
				vtime_nx[i]  = '0;
			end
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_nx[i] = rest_q;
			end
			slot_nx     = '0;
			prev_avg_nx = rest_q;
			win_pos_nx  = '0;
			tick_nx     = '0;
			walk_nx     = 1'b0;
		end else begin
			win_nx     = win_wr;
			win_pos_nx = pos_adv;
			tick_nx    = now;
			if (cur >= prev_avg_q) begin
				if (cur >= pk) begin
					// New peak: the valley restarts from it.
					peak_nx[slot_q]   = cur;
					valley_nx[slot_q] = cur;
					vtime_nx[slot_q]  = now;
					prev_avg_nx       = cur;
				end else if (falling && (vt >= min_valley_q) && (pk > thr_q.high)) begin
					step     = 1'b1;
					walk_nx  = 1'b1;
					steps_nx = steps_q + 32'd1;
					dist_nx  = dist_q + 32'(stride_q);
					tick_nx  = '0;
					if (last_slot) begin
						// All slots filled: adapt and clear them.
						slot_nx = '0;
						thr_nx  = thr_adapt;
						for (int i = 0; i < SLOTS; i++) begin
							peak_nx[i]   = rest_q;
							valley_nx[i] = rest_q;
							vtime_nx[i]  = '0;
						end
					end else begin
						// The next slot starts from the base thresholds; its
						// valley time is left untouched.
						slot_nx             = slot_inc;
						peak_nx[slot_inc]   = base_up_q;
						valley_nx[slot_inc] = base_down_q;
					end
					for (int i = 0; i < WINDOW_LEN; i++) begin
						win_nx[i] = rest_q;
					end
					win_pos_nx  = '0;
					prev_avg_nx = rest_q;
				end else begin
					prev_avg_nx = cur;
				end
			end else begin
				if (cur < vl) begin
					valley_nx[slot_q] = cur;
					vtime_nx[slot_q]  = now;
				end
				prev_avg_nx = cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= RST_REST_LEVEL;
			end
			for (int i = 0; i < SLOTS; i++) begin
				peak_q[i]   <= RST_REST_LEVEL;
				valley_q[i] <= RST_REST_LEVEL;
				vtime_q[i]  <= '0;
			end
			win_pos_q    <= '0;
			prev_avg_q   <= RST_REST_LEVEL;
			slot_q       <= '0;
			thr_q.high   <= RST_THR_UP;
			thr_q.low    <= RST_THR_DOWN;
			thr_q.swing  <= RST_THR_WIDE;
			tick_q       <= '0;
			steps_q      <= '0;
			dist_q       <= '0;
			walking_q    <= 1'b0;
			step_now_q   <= 1'b0;
		end else if (advance) begin
			win_q      <= win_nx;
			win_pos_q  <= win_pos_nx;
			prev_avg_q <= prev_avg_nx;
			peak_q     <= peak_nx;
			valley_q   <= valley_nx;
			vtime_q    <= vtime_nx;
			slot_q     <= slot_nx;
			thr_q      <= thr_nx;
			tick_q     <= tick_nx;
			steps_q    <= steps_nx;
			dist_q     <= dist_nx;
			walking_q  <= walk_nx;
			step_now_q <= step;
		end
	end

	// The totals and the walking flag double as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid   = result_valid_q;
	assign step_now       = step_now_q;
	assign steps_total    = steps_q;
	assign distance_total = dist_q;
	assign walking        = walking_q;

	`APV_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, result_valid_q, "processed sample produced no result beat")
	`APV_ASSERT_NEXT(a_step_restarts_tick, clk, arst_n, advance && step, (tick_q == 8'd0) && walking_q && step_now_q, "counted step did not clear tick count or set walking")
	`APV_ASSERT_NEXT(a_step_counts_once, clk, arst_n, advance && step, steps_q == $past(steps_q) + 32'd1, "step counter did not advance by one on a step")
	`APV_ASSERT(a_slot_in_range, clk, arst_n, (slot_q <= IDX_W'(SLOTS - 1)) && (win_pos_q <= IDX_W'(WINDOW_LEN - 1)), "slot index or window position out of range")

endmodule

// ===== rtl/apvsd_adapt.sv =====
// Adapted thresholds: each one halfway between its base and the mean of the slot peaks, valleys or swings.
// Purely combinational; depends on apvsd_pkg.
module apvsd_adapt (
	input  logic [15:0]        peak [apvsd_pkg::SLOTS],
	input  logic [15:0]        valley [apvsd_pkg::SLOTS],
	input  logic [15:0]        base_up,
	input  logic [15:0]        base_down,
	input  logic [15:0]        base_wide,
	output apvsd_pkg::thr_t    thr
);
	import apvsd_pkg::*;

	logic [SUM_W-1:0]        sum_p;
	logic [SUM_W-1:0]        sum_v;
	logic signed [SUM_W:0]   sum_d;
	logic [SUM_W:0]          mag_d;
	logic [15:0]             q5;
	logic signed [17:0]      mean_d;
	logic signed [17:0]      t_d;
	logic signed [17:0]      q_d;
	logic [16:0]             t_h;
	logic [16:0]             t_l;

	always_comb begin
		sum_p = '0;
		sum_v = '0;
		for (int i = 0; i < SLOTS; i++) begin
			sum_p = sum_p + SUM_W'(peak[i]);
			sum_v = sum_v + SUM_W'(valley[i]);
		end
		// The swing sum equals the peak sum minus the valley sum.
		sum_d = $signed({1'b0, sum_p}) - $signed({1'b0, sum_v});
		// Divide the magnitude so the quotient truncates toward zero.
		mag_d = sum_d[SUM_W] ? (SUM_W + 1)'(-sum_d) : (SUM_W + 1)'(sum_d);
		q5 = div5(mag_d[SUM_W-1:0]);
		mean_d = sum_d[SUM_W] ? -$signed({2'b00, q5}) : $signed({2'b00, q5});
		t_d = mean_d + $signed({2'b00, base_wide});
		// Halving also truncates toward zero for a negative sum.
		q_d = t_d[17] ? ((t_d + 18'sd1) >>> 1) : (t_d >>> 1);

		t_h = 17'(div5(sum_p)) + 17'(base_up);
		t_l = 17'(div5(sum_v)) + 17'(base_down);
		thr.high  = t_h[16:1];
		thr.low   = t_l[16:1];
		thr.swing = q_d[15:0];
	end

endmodule

// ===== bench/adaptive_peak_valley_step_detector_core_tb.sv =====
// Self-checking testbench for the adaptive peak/valley step detector core.
// Depends on apvsd_pkg and the core RTL only; drives samples and configuration
// writes and compares every result beat against its own behavioral predictor.
`timescale 1ns / 100ps

module adaptive_peak_valley_step_detector_core_tb;
	import apvsd_pkg::*;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 175;
	localparam int MAX_REPORTS    = 10;
	// No beat of any kind for this many cycles means the core has hung.
	localparam int WATCHDOG_LIMIT = 2000;

	// One result beat as the core presents it.
	typedef struct packed {
		logic        step_now;
		logic [31:0] steps_total;
		logic [31:0] distance_total;
		logic        walking;
	} step_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic [15:0] sample = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        step_now;
	logic [31:0] steps_total;
	logic [31:0] distance_total;
	logic        walking;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_reg_t    cfg_index = REG_THR_UP;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	adaptive_peak_valley_step_detector_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.step_now       (step_now),
		.steps_total    (steps_total),
		.distance_total (distance_total),
		.walking        (walking),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state. The configuration copy is updated on every accepted
	// configuration beat; the tracking state advances once per sample beat.
	// ------------------------------------------------------------------
	logic [15:0] cfg_thr_up, cfg_thr_down, cfg_thr_wide, cfg_rest;
	logic [7:0]  cfg_stride, cfg_timeout, cfg_min_valley;

	logic [15:0] avg_buf [WINDOW_LEN];
	logic [2:0]  avg_ptr;
	logic [15:0] prev_mean;
	logic [15:0] peak_of [SLOTS];
	logic [15:0] valley_of [SLOTS];
	logic [7:0]  valley_tick [SLOTS];
	logic [2:0]  slot;
	logic [15:0] hi_thr, lo_thr, swing_thr;
	logic [7:0]  tick;
	logic [31:0] step_cnt, dist_cnt;
	logic        is_walking;

	// Results predicted for accepted samples, oldest first.
	step_beat_t  expected_beats [$];
	// Samples waiting for the driver.
	logic [15:0] sample_pending [$];

	int  idle_pct = 0;
	int  stall_pct = 0;
	int  pushed = 0;
	int  mismatches = 0;
	int  results_seen = 0;
	int  quiet_cycles = 0;
	logic sample_took = 1'b0;

	function automatic void refill_average();
		int i;
		for (i = 0; i < WINDOW_LEN; i++)
			avg_buf[i] = cfg_rest;
		prev_mean = cfg_rest;
	endfunction

	function automatic void reload_slots();
		int i;
		for (i = 0; i < SLOTS; i++) begin
			peak_of[i] = cfg_rest;
			valley_of[i] = cfg_rest;
			valley_tick[i] = '0;
		end
	endfunction

	// Timeout behavior: thresholds back to base, slots and window refilled,
	// positions and walking flag cleared. The running totals survive.
	function automatic void restart_detector();
		hi_thr = cfg_thr_up;
		lo_thr = cfg_thr_down;
		swing_thr = cfg_thr_wide;
		reload_slots();
		slot = '0;
		refill_average();
		avg_ptr = '0;
		tick = '0;
		is_walking = 1'b0;
	endfunction

	// After the last slot completes, each threshold moves halfway from its base
	// toward the slot mean. The swing sum is signed since a valley may sit above
	// its peak; the division truncates toward zero and the low 16 bits are kept.
	function automatic void retune_thresholds();
		int unsigned sum_p, sum_v;
		int sum_d, q, i;
		sum_p = 0;
		sum_v = 0;
		sum_d = 0;
		for (i = 0; i < SLOTS; i++) begin
			sum_p += peak_of[i];
			sum_v += valley_of[i];
			sum_d += int'(peak_of[i]) - int'(valley_of[i]);
		end
		hi_thr = 16'((sum_p / SLOTS + cfg_thr_up) / 2);
		lo_thr = 16'((sum_v / SLOTS + cfg_thr_down) / 2);
		q = (sum_d / SLOTS + int'(cfg_thr_wide)) / 2;
		swing_thr = q[15:0];
	endfunction

	// Advances the predictor by one tick and returns the result beat it causes.
	task automatic track_tick(input logic [15:0] smp, output step_beat_t r);
		int unsigned sum;
		logic [15:0] cur;
		logic stepped, falling;
		int s, i;
		stepped = 1'b0;
		if (tick >= cfg_timeout) begin
			restart_detector();
		end else begin
			tick = tick + 8'd1;
			// The position moves before the write, so the first sample after a
			// restart lands in entry one.
			if (avg_ptr == WINDOW_LEN - 1)
				avg_ptr = '0;
			else
				avg_ptr = avg_ptr + 3'd1;
			avg_buf[avg_ptr] = smp;
			sum = 0;
			for (i = 0; i < WINDOW_LEN; i++)
				sum += avg_buf[i];
			cur = 16'(sum / WINDOW_LEN);
			s = slot;
			if (cur >= prev_mean) begin
				falling = (cur < lo_thr) ||
					(int'(peak_of[s]) - int'(valley_of[s]) > int'(swing_thr));
				if (cur >= peak_of[s]) begin
					peak_of[s] = cur;
					valley_of[s] = cur;
					valley_tick[s] = tick;
					prev_mean = cur;
				end else if (falling && valley_tick[s] >= cfg_min_valley &&
						peak_of[s] > hi_thr) begin
					stepped = 1'b1;
					is_walking = 1'b1;
					step_cnt = step_cnt + 32'd1;
					dist_cnt = dist_cnt + 32'(cfg_stride);
					tick = '0;
					avg_ptr = '0;
					if (s == SLOTS - 1) begin
						slot = '0;
						retune_thresholds();
						reload_slots();
					end else begin
						// A new slot starts from the base thresholds; its valley
						// time is left over from the previous round.
						slot = 3'(s + 1);
						peak_of[slot] = cfg_thr_up;
						valley_of[slot] = cfg_thr_down;
					end
					refill_average();
				end else begin
					prev_mean = cur;
				end
			end else begin
				if (cur < valley_of[s]) begin
					valley_of[s] = cur;
					valley_tick[s] = tick;
				end
				prev_mean = cur;
			end
		end
		r.step_now = stepped;
		r.steps_total = step_cnt;
		r.distance_total = dist_cnt;
		r.walking = is_walking;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result %0d, %s: expected %0d, got %0d",
					results_seen, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Sample driver. A new beat is offered only once the previous one has
	// been taken, so a stalled beat holds its value. The idle decision never
	// looks at the stall. The result stall is redrawn every cycle.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_valid || sample_took) begin
				if (sample_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
					sample <= sample_pending.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks result beats, predicts for accepted sample beats and
	// runs the watchdog. The check comes before the prediction so that a
	// result sharing a cycle with a new sample is matched against older work.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		step_beat_t want;
		logic took_in, took_out;
		took_in = sample_valid && !sample_stall;
		took_out = result_valid && !result_stall;
		if (arst_n) begin
			if (took_out) begin
				results_seen++;
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d arrived with no sample outstanding",
							results_seen);
				end else begin
					want = expected_beats.pop_front();
					check_field("step_now", 32'(want.step_now), 32'(step_now));
					check_field("steps_total", want.steps_total, steps_total);
					check_field("distance_total", want.distance_total, distance_total);
					check_field("walking", 32'(want.walking), 32'(walking));
				end
			end
			if (took_in) begin
				track_tick(sample, want);
				expected_beats.push_back(want);
			end
			sample_took <= took_in;
			if (took_in || took_out || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic add_sample(input int v);
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		sample_pending.push_back(16'(v));
		pushed++;
	endtask

	// Drives one configuration beat and mirrors it into the predictor. The
	// valid stays high between back-to-back writes.
	task automatic write_reg(input cfg_reg_t idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THR_UP:     cfg_thr_up = 16'(val);
			REG_THR_DOWN:   cfg_thr_down = 16'(val);
			REG_THR_WIDE:   cfg_thr_wide = 16'(val);
			REG_REST_LEVEL: cfg_rest = 16'(val);
			REG_STRIDE:     cfg_stride = 8'(val);
			REG_TIMEOUT:    cfg_timeout = 8'(val);
			REG_MIN_VALLEY: cfg_min_valley = 8'(val);
			default: ;
		endcase
	endtask

	task automatic write_settings(input int up, down, wide, rest, stride, tmo, minv);
		write_reg(REG_THR_UP, up);
		write_reg(REG_THR_DOWN, down);
		write_reg(REG_THR_WIDE, wide);
		write_reg(REG_REST_LEVEL, rest);
		write_reg(REG_STRIDE, stride);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_MIN_VALLEY, minv);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Quiet point: nothing queued, nothing offered, nothing outstanding.
	task automatic wait_drained();
		while (sample_pending.size() != 0 || sample_valid || expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int phase, mode, pick, k, lo, hi, rise, len, v;
		int up, down, wide, rest, stride, tmo, minv;

		// Predictor starts from the register reset values.
		cfg_thr_up = RST_THR_UP;
		cfg_thr_down = RST_THR_DOWN;
		cfg_thr_wide = RST_THR_WIDE;
		cfg_rest = RST_REST_LEVEL;
		cfg_stride = RST_STRIDE;
		cfg_timeout = RST_TIMEOUT;
		cfg_min_valley = RST_MIN_VALLEY;
		restart_detector();
		step_cnt = '0;
		dist_cnt = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings with no idling: sample extremes, a
		// spike that settles to rest, then a large swing late enough in the
		// tick count that the valley time qualifies and a step is counted.
		add_sample(0);
		add_sample(65535);
		repeat (17) add_sample(RST_REST_LEVEL);
		repeat (3) add_sample(65535);
		repeat (3) add_sample(0);
		add_sample(65535);

		for (phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			repeat (4) @(posedge clk);
			case (phase)
				0: begin
					// Reset values written back explicitly.
					up = RST_THR_UP; down = RST_THR_DOWN; wide = RST_THR_WIDE;
					rest = RST_REST_LEVEL; stride = RST_STRIDE;
					tmo = RST_TIMEOUT; minv = RST_MIN_VALLEY;
				end
				2: begin
					// Everything permissive: steps on almost any rise.
					up = 0; down = 65535; wide = 0; rest = 65535;
					stride = 255; tmo = 255; minv = 0;
				end
				3: begin
					// Everything restrictive: a timeout on every other tick.
					up = 65535; down = 0; wide = 65535; rest = 0;
					stride = 0; tmo = 1; minv = 255;
				end
				5: begin
					// Low base above high base, so a fresh slot starts with its
					// valley over its peak and a negative swing.
					up = $urandom_range(800, 1200); down = $urandom_range(1500, 3000);
					wide = $urandom_range(0, 1000); rest = $urandom_range(0, 65535);
					stride = $urandom_range(0, 255); tmo = $urandom_range(20, 60);
					minv = $urandom_range(0, 8);
				end
				7: begin
					up = $urandom_range(0, 65535); down = $urandom_range(0, 65535);
					wide = $urandom_range(0, 65535); rest = $urandom_range(0, 65535);
					stride = $urandom_range(0, 255); tmo = $urandom_range(1, 255);
					minv = $urandom_range(0, 255);
				end
				default: begin
					up = $urandom_range(1200, 4000); down = $urandom_range(0, 900);
					wide = $urandom_range(100, 2000); rest = $urandom_range(900, 1100);
					stride = $urandom_range(0, 255); tmo = $urandom_range(40, 120);
					minv = $urandom_range(0, 15);
				end
			endcase
			write_settings(up, down, wide, rest, stride, tmo, minv);

			mode = phase % 4;
			idle_pct = (mode == 1) ? 56 : (mode == 3) ? 20 : 0;
			stall_pct = (mode == 2) ? 56 : (mode == 3) ? 20 : 0;

			pushed = 0;
			while (pushed < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					// One stride: a ramp up to a peak and a fall to a valley, long enough for
					// the valley time to qualify unless the length cap of 60 cuts it short.
					lo = $urandom_range(0, 900);
					hi = $urandom_range(1600, 9000);
					if ($urandom_range(9) == 0) begin
						lo = 0;
						hi = 65535;
					end
					rise = $urandom_range(2, 10);
					len = cfg_min_valley + $urandom_range(2, 12);
					if (len > 60)
						len = 60;
					if (len < rise + 3)
						len = rise + 3;
					for (k = 0; k < len; k++) begin
						if (k < rise)
							v = lo + (hi - lo) * (k + 1) / rise;
						else
							v = hi - (hi - lo) * (k - rise + 1) / (len - rise);
						add_sample(v + $urandom_range(0, 32) - 16);
					end
				end else if (pick < 85) begin
					// Noise burst over the full range, extremes included.
					repeat ($urandom_range(1, 8)) begin
						case ($urandom_range(3))
							0: add_sample(0);
							1: add_sample(65535);
							default: add_sample($urandom_range(0, 65535));
						endcase
					end
				end else begin
					// Standing still: short pauses, or stretches near the timeout length.
					if ($urandom_range(1) == 0)
						len = $urandom_range(1, 8);
					else
						len = cfg_timeout + $urandom_range(0, 6) - 3;
					if (len < 1)
						len = 1;
					repeat (len) add_sample(cfg_rest + $urandom_range(0, 8) - 4);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_beats.size() != 0) begin
			mismatches += expected_beats.size();
			$display("%0d expected results never arrived", expected_beats.size());
		end
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/apvsd_pkg.sv
rtl/apvsd_adapt.sv
rtl/adaptive_peak_valley_step_detector_core.sv
bench/adaptive_peak_valley_step_detector_core_tb.sv
